>>> rtl/core/bdq_pkg.sv
// Shared types and constants for the bounded deque with dump.
package bdq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = IDX_W + 1;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_DUMP      = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_WAIT = 2'd2
  } back_state_e;

  // Work handed from front to back: a plain status beat or a dump walk.
  typedef struct packed {
    logic             is_dump;
    status_e          status;
    logic [IDX_W-1:0] front;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // Ring wrap helpers, no divider: values stay below twice the capacity.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == IDX_W'(CAPACITY - 1)) r = '0;
    else                             r = idx + IDX_W'(1);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == '0) r = IDX_W'(CAPACITY - 1);
    else           r = idx - IDX_W'(1);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(idx) + SUM_W'(off);
    if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/core/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bdq_front.sv
// Front end: accepts beats, updates ring pointers, writes the store, queues work.
module bdq_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bdq_pkg::OP_W-1:0]  opcode_i,
  input  logic [bdq_pkg::DATA_W-1:0] value_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output bdq_pkg::cmd_t             q_cmd_o,
  input  logic                      dump_done_i,
  output logic                      ram_we_o,
  output logic [bdq_pkg::IDX_W-1:0] ram_waddr_o,
  output logic [bdq_pkg::DATA_W-1:0] ram_wdata_o
);
  import bdq_pkg::*;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             busy_q, busy_d;
  logic             accept, is_full, is_empty;

  assign in_stall_o = busy_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == CNT_W'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign ram_wdata_o = value_i;

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    busy_d      = busy_q;
    q_push_o    = 1'b0;
    q_cmd_o     = '{is_dump: 1'b0, status: ST_OK, front: front_q, count: count_q};
    ram_we_o    = 1'b0;
    ram_waddr_o = front_q;
    if (dump_done_i) busy_d = 1'b0;
    if (accept) begin
      q_push_o = 1'b1;
      case (opcode_e'(opcode_i))
        OP_INS_FRONT: begin
          if (is_full) begin
            q_cmd_o.status = ST_FULL;
          end else begin
            front_d     = idx_dec(front_q);
            ram_we_o    = 1'b1;
            ram_waddr_o = idx_dec(front_q);
            count_d     = count_q + CNT_W'(1);
          end
        end
        OP_INS_BACK: begin
          if (is_full) begin
            q_cmd_o.status = ST_FULL;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = idx_add(front_q, count_q);
            count_d     = count_q + CNT_W'(1);
          end
        end
        OP_DEL_FRONT: begin
          if (is_empty) begin
            q_cmd_o.status = ST_EMPTY;
          end else begin
            front_d = idx_inc(front_q);
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_DEL_BACK: begin
          if (is_empty) begin
            q_cmd_o.status = ST_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_DUMP: begin
          if (is_empty) begin
            q_cmd_o.status = ST_EMPTY;
          end else begin
            // hold off input until the back end has read every element
            q_cmd_o.is_dump = 1'b1;
            busy_d          = 1'b1;
          end
        end
        default: begin
          q_push_o = 1'b0;  // unused opcodes: swallowed, no result
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      busy_q  <= busy_d;
    end
  end

endmodule

>>> rtl/core/bdq_cmd_fifo.sv
// Short command queue between front and back.
module bdq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bdq_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bdq_pkg::cmd_t cmd_o
);
  import bdq_pkg::*;

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/bdq_back.sv
// Back end: turns queued work into result beats, walking the store for dumps.
module bdq_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  bdq_pkg::cmd_t              q_cmd_i,
  output logic                       q_pop_o,
  output logic                       ram_re_o,
  output logic [bdq_pkg::IDX_W-1:0]  ram_raddr_o,
  input  logic [bdq_pkg::DATA_W-1:0] ram_rdata_i,
  output logic                       dump_done_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [bdq_pkg::DATA_W-1:0] element_o,
  output logic [bdq_pkg::STAT_W-1:0] status_o,
  output logic                       last_o
);
  import bdq_pkg::*;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  off_q, off_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              rd_last_q, rd_last_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_elem_q, out_elem_d;
  status_e           out_stat_q, out_stat_d;
  logic              out_last_q, out_last_d;
  logic              out_free, is_last_rd;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_last_rd = (off_q == total_q - CNT_W'(1));
  assign ram_raddr_o = ptr_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    off_d       = off_q;
    total_d     = total_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_elem_d  = out_elem_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;
    ram_re_o    = 1'b0;
    dump_done_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          if (q_cmd_i.is_dump) begin
            q_pop_o = 1'b1;
            ptr_d   = q_cmd_i.front;
            total_d = q_cmd_i.count;
            off_d   = '0;
            state_d = B_READ;
          end else if (out_free) begin
            q_pop_o     = 1'b1;
            out_valid_d = 1'b1;
            out_elem_d  = '0;
            out_stat_d  = q_cmd_i.status;
            out_last_d  = 1'b1;
          end
        end
      end
      B_READ: begin
        ram_re_o    = 1'b1;
        rd_last_d   = is_last_rd;
        dump_done_o = is_last_rd;
        ptr_d       = idx_inc(ptr_q);
        off_d       = off_q + CNT_W'(1);
        state_d     = B_WAIT;
      end
      B_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_elem_d  = ram_rdata_i;
          out_stat_d  = ST_OK;
          out_last_d  = rd_last_q;
          state_d     = rd_last_q ? B_IDLE : B_READ;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    off_q      <= off_d;
    total_q    <= total_d;
    rd_last_q  <= rd_last_d;
    out_elem_q <= out_elem_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = out_elem_q;
  assign status_o    = out_stat_q;
  assign last_o      = out_last_q;

endmodule

>>> rtl/core/bounded_deque_with_dump_unit.sv
// Top level of the bounded deque with dump: front end, command queue, back end, store.
// Bounded double-ended queue of CAPACITY (16) signed 32-bit words held in a ring
// store with a front index and a count. Opcodes: 0 insert front, 1 insert back,
// 2 delete front, 3 delete back, 4 dump; 5..7 are taken and dropped without a
// result. Each insert or delete yields one beat with status ok, empty or full
// (element 0, last 1). A dump yields one beat per element, front to back, last
// set on the final one; an empty dump yields one empty beat. Rate: inserts and
// deletes are taken one per cycle while the input is not stalled, since the front
// end updates the pointers and writes the store in the cycle of acceptance; status
// beats leave one per cycle, when the output is not stalled, through a four-entry
// command queue and the output register. In the back end a dump first takes the
// command, then does one store read plus one output load per element through the
// registered read port. Input is stalled from the dump's acceptance until its
// last element has been read. The store needs no clearing after reset; only
// written slots are ever read.
module bounded_deque_with_dump_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bdq_pkg::DATA_W-1:0] element_o,
  output logic [bdq_pkg::STAT_W-1:0]        status_o,
  output logic                              last_o
);
  import bdq_pkg::*;

  // front -> queue
  logic             q_push, q_full, q_pop, q_empty;
  cmd_t             q_cmd_in, q_cmd_out;
  // store ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  // back -> front: last dump read issued, input may resume
  logic             dump_done;

  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in),
    .dump_done_i (dump_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  bdq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd_out)
  );

  bdq_ram #(
    .Width (DATA_W),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .dump_done_o (dump_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_o   (element_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

>>> tb/sv/deque_checker.sv
`timescale 1ns / 100ps
// Checker for the bounded deque: watches both channels, predicts result beats, compares them.
module deque_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [bdq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] element_i,
  input  logic [bdq_pkg::STAT_W-1:0]        status_i,
  input  logic                              last_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                checked_o
);
  import bdq_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] element;
    status_e                  status;
    logic                     last;
  } result_beat_t;

  // Shadow deque: ring of words, head slot and fill level.
  logic signed [DATA_W-1:0] ring [CAPACITY];
  int unsigned              head;
  int unsigned              fill;
  result_beat_t             beats_due [$];

  int n_errors  = 0;
  int n_pending = 0;
  int n_checked = 0;

  assign errors_o  = n_errors;
  assign pending_o = n_pending;
  assign checked_o = n_checked;

  function automatic void queue_beat(input logic signed [DATA_W-1:0] elem,
                                     input status_e st, input logic fin);
    result_beat_t b;
    b.element = elem;
    b.status  = st;
    b.last    = fin;
    beats_due.push_back(b);
  endfunction

  task automatic predict_command(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val);
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (fill >= CAPACITY) begin
          queue_beat('0, ST_FULL, 1'b1);
        end else begin
          if (op == OP_INS_FRONT) begin
            head = (head + CAPACITY - 1) % CAPACITY;
            ring[head] = val;
          end else begin
            ring[(head + fill) % CAPACITY] = val;
          end
          fill++;
          queue_beat('0, ST_OK, 1'b1);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (fill == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
        end else begin
          if (op == OP_DEL_FRONT) head = (head + 1) % CAPACITY;
          fill--;
          queue_beat('0, ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++)
            queue_beat(ring[(head + i) % CAPACITY], ST_OK, i + 1 == fill);
        end
      end
      default: ; // unused opcodes are dropped silently
    endcase
  endtask

  task automatic compare_beat();
    result_beat_t due;
    n_checked++;
    if (beats_due.size() == 0) begin
      n_errors++;
      $display("%0t: result beat with none expected: element %0d status %0d last %0b",
               $time, element_i, status_i, last_i);
    end else begin
      due = beats_due.pop_front();
      if (element_i !== due.element) begin
        n_errors++;
        $display("%0t: element mismatch: expected %0d, got %0d", $time, due.element, element_i);
      end
      if (status_i !== due.status) begin
        n_errors++;
        $display("%0t: status mismatch: expected %0d, got %0d", $time, due.status, status_i);
      end
      if (last_i !== due.last) begin
        n_errors++;
        $display("%0t: last mismatch: expected %0b, got %0b", $time, due.last, last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head = 0;
      fill = 0;
      beats_due.delete();
      n_pending = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_command(opcode_i, value_i);
      if (out_valid_i && !out_stall_i) compare_beat();
      n_pending = beats_due.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the bounded deque with dump: stimulus, output stalls and verdict.
module tb;
  import bdq_pkg::*;

  localparam int RANDOM_CMDS = 344;  // plus the directed opening, about 370 in all
  localparam int PHASES      = 4;
  localparam int HOLD_CYCLES = 150;  // long receiver hold-off, fills the command queue
  localparam int DRAIN_WAIT  = 40;   // margin to cover a full dump walk

  // Opcodes outside the defined set; the block takes and drops them.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic [OP_W-1:0]          opcode_i    = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] element_o;
  logic [STAT_W-1:0]        status_o;
  logic                     last_o;

  int n_errors;
  int n_pending;
  int n_checked;

  // Stimulus knobs, shared between the sender and the receiver process.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit long_hold     = 1'b0;

  // Rough fill level as seen by the stimulus; only used to steer the
  // random mix between growing to full and draining to empty.
  int est_fill = 0;
  bit growing  = 1'b1;

  int n_cmds    = 0;
  int n_dumps   = 0;
  int n_dropped = 0;

  bounded_deque_with_dump_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_o   (element_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  deque_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_i   (element_o),
    .status_i    (status_o),
    .last_i      (last_o),
    .errors_o    (n_errors),
    .pending_o   (n_pending),
    .checked_o   (n_checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls per the current mix; on request one long
  // hold-off, counted here, while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [DATA_W-1:0] corner_value(input int k);
    case (k % 5)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Offer one beat and hold it until taken. Valid stays high on return so
  // back-to-back beats never drop it; a gap lowers it at the next call.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    case (op)
      OP_INS_FRONT, OP_INS_BACK: if (est_fill < CAPACITY) est_fill++;
      OP_DEL_FRONT, OP_DEL_BACK: if (est_fill > 0) est_fill--;
      default: ;
    endcase
    if (est_fill == CAPACITY) growing = 1'b0;
    if (est_fill == 0)        growing = 1'b1;

    if (op > OP_DUMP) n_dropped++;
    else              n_cmds++;
    if (op == OP_DUMP) n_dumps++;
  endtask

  // Random command: a little noise, some dumps, and inserts/deletes biased
  // to sweep the deque between empty and full again and again.
  task automatic send_random();
    int              r;
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] val;
    r = $urandom_range(99);
    if (r < 4) begin
      op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    end else if (r < 14) begin
      op = OP_DUMP;
    end else if (growing ? (r < 84) : (r < 30)) begin
      op = $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
    end else begin
      op = $urandom_range(1) ? OP_DEL_BACK : OP_DEL_FRONT;
    end
    val = ($urandom_range(9) < 3) ? corner_value($urandom_range(4)) : $urandom;
    send_beat(op, val);
  endtask

  initial begin
    int  target;
    bit  hold_done;
    hold_done = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: everything on an empty deque, unused opcodes, fill with
    // corner values, refused inserts on full, full dump, both deletes, another dump.
    send_beat(OP_DUMP, '0);
    send_beat(OP_DEL_FRONT, '0);
    send_beat(OP_DEL_BACK, '0);
    for (int c = OP_FIRST_UNUSED; c <= OP_LAST_UNUSED; c++) send_beat(OP_W'(c), $urandom);
    for (int k = 0; k < CAPACITY; k++)
      send_beat(k[0] ? OP_INS_BACK : OP_INS_FRONT, (k < 5) ? corner_value(k) : $urandom);
    send_beat(OP_INS_FRONT, $urandom);
    send_beat(OP_INS_BACK, $urandom);
    send_beat(OP_DUMP, '0);
    send_beat(OP_DEL_FRONT, '0);
    send_beat(OP_DEL_BACK, '0);
    send_beat(OP_DUMP, '0);

    // Random phases: no idling, sender gaps, receiver stalls, both.
    target = n_cmds;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 47; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      target += RANDOM_CMDS / PHASES;
      while (n_cmds < target) begin
        // Mid-way through the fast phase: back up the output for a while.
        if (p == 0 && !hold_done && n_cmds + 50 >= target) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        send_random();
      end
    end

    // Last beat was taken at this edge; lower valid and drain.
    in_valid_i <= 1'b0;
    stall_pct  = 0;
    while (n_pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d commands (%0d dumps) plus %0d dropped unused opcodes,",
             n_cmds, n_dumps, n_dropped);
    $display("with %0d result beats compared across empty/full sweeps and a long output hold.",
             n_checked);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> bounded_deque_with_dump_unit.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_front.sv
rtl/core/bdq_cmd_fifo.sv
rtl/core/bdq_back.sv
rtl/core/bounded_deque_with_dump_unit.sv
tb/sv/deque_checker.sv
tb/sv/tb.sv
